// ----- rtl/aabb_frustum_cull_defines.svh -----
// Assertion macros shared by the frustum cull checker.
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define AFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aabb_frustum_cull: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define AFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aabb_frustum_cull: next-cycle check failed");

`endif

// ----- rtl/afc_pkg.sv -----
// Shared constants and types for the box frustum cull block.
package afc_pkg;

    localparam int NUM_REGS        = 6;
    localparam int CFG_IDX_W       = $clog2(NUM_REGS);
    localparam int PLANE_W         = 64;
    localparam int NORM_W          = 12;
    localparam int OFFS_W          = 28;
    localparam int OFFS_SHIFT      = 10;
    localparam int NUM_AXES        = 3;
    localparam int NUM_FIELDS      = 2 * NUM_AXES;
    localparam int OUT_TDATA_W     = 8;
    localparam int PIPE_DEPTH      = 3;
    localparam int DEF_NUM_PLANES  = 6;
    localparam int DEF_COORD_WIDTH = 24;

    // Matches the packed register word: nx in the top bits, offset at the bottom.
    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic signed [OFFS_W-1:0] d;
    } plane_t;

    typedef struct packed {
        logic prod;
        logic flag;
    } pipe_en_t;

endpackage

// ----- rtl/afc_plane_regs.sv -----
// Plane register file written through the configuration port.
module afc_plane_regs
    import afc_pkg::*;
#(
    parameter int ACTIVE = NUM_REGS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PLANE_W-1:0]   cfg_data,
    output plane_t               planes [ACTIVE]
);

    plane_t plane_reg [ACTIVE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                if (cfg_we && (cfg_index == CFG_IDX_W'(i)))
                begin
                    plane_reg[i] <= plane_t'(cfg_data);
                end
            end
        end
    end

    assign planes = plane_reg;

endmodule

// ----- rtl/afc_plane_test.sv -----
// Test of one plane against the box's farthest corner along the plane normal.
module afc_plane_test
    import afc_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
)
(
    input  logic                          clk,
    input  pipe_en_t                      en,
    input  plane_t                        plane,
    input  logic signed [COORD_WIDTH-1:0] coord_lo [NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0] coord_hi [NUM_AXES],
    output logic                          reject
);

    localparam int PROD_W     = NORM_W + COORD_WIDTH;
    localparam int OFFS_EXT_W = OFFS_W + OFFS_SHIFT;
    localparam int SUM_W      = ((PROD_W > OFFS_EXT_W) ? PROD_W : OFFS_EXT_W) + 2;

    logic signed [NORM_W-1:0]      norm [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] sel [NUM_AXES];
    logic signed [PROD_W-1:0]      prod_next [NUM_AXES];
    logic signed [PROD_W-1:0]      prod_reg [NUM_AXES];
    logic signed [SUM_W-1:0]       sum;
    logic                          reject_next;
    logic                          reject_reg;

    assign norm[0] = plane.nx;
    assign norm[1] = plane.ny;
    assign norm[2] = plane.nz;

    // The corner with the largest value picks, per axis, the high coordinate
    // for a non-negative normal component and the low one otherwise.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sel[a]       = norm[a][NORM_W-1] ? coord_lo[a] : coord_hi[a];
            prod_next[a] = PROD_W'(norm[a]) * PROD_W'(sel[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
            + (SUM_W'(plane.d) <<< OFFS_SHIFT);
        reject_next = sum[SUM_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en.flag)
        begin
            reject_reg <= reject_next;
        end
    end

    assign reject = reject_reg;

endmodule

// ----- rtl/aabb_frustum_cull.sv -----
// Top level of the axis-aligned box frustum cull block.
//
//  Channel  Direction  Handshake          Contents
//  s_*      in         tvalid/tready      one box: min x,y,z then max x,y,z
//  m_*      out        tvalid/tready      culled flag
//  cfg_*    in         write enable only  plane register writes
//
// One box is accepted per cycle while s_tready is high; it passes through the
// input register, the product register of each plane and then the flag register.
// Reset clears the planes, so no box is culled.
// A stall on the output holds the stages that carry a request, lets empty
// stages fill, and drops s_tready only once all three stages are full.
module aabb_frustum_cull
    import afc_pkg::*;
#(
    parameter int  NUM_PLANES  = DEF_NUM_PLANES,
    parameter int  COORD_WIDTH = DEF_COORD_WIDTH,
    localparam int IN_TDATA_W  = ((NUM_FIELDS * COORD_WIDTH + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // culled
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [PLANE_W-1:0]     cfg_data
);

    localparam int ACTIVE = (NUM_PLANES < NUM_REGS) ? NUM_PLANES : NUM_REGS;

    plane_t                        planes [ACTIVE];
    logic signed [COORD_WIDTH-1:0] box_min [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] box_max [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] lo_next [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] hi_next [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] lo_reg [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] hi_reg [NUM_AXES];
    logic                          v1_reg;
    logic                          v2_reg;
    logic                          v3_reg;
    logic                          en1;
    logic                          en2;
    logic                          en3;
    pipe_en_t                      en;
    logic [ACTIVE-1:0]             reject;

    afc_plane_regs #(
        .ACTIVE(ACTIVE)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .planes   (planes)
    );

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign en.prod  = en2 && v1_reg;
    assign en.flag  = en3 && v2_reg;

    // Corners are ordered per axis so that the plane test needs only a select.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            box_min[a] = s_tdata[a * COORD_WIDTH +: COORD_WIDTH];
            box_max[a] = s_tdata[(a + NUM_AXES) * COORD_WIDTH +: COORD_WIDTH];
            if (box_min[a] <= box_max[a])
            begin
                lo_next[a] = box_min[a];
                hi_next[a] = box_max[a];
            end
            else
            begin
                lo_next[a] = box_max[a];
                hi_next[a] = box_min[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && en1)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    for (genvar p = 0; p < ACTIVE; p++)
    begin : g_plane
        afc_plane_test #(
            .COORD_WIDTH(COORD_WIDTH)
        ) u_test (
            .clk     (clk),
            .en      (en),
            .plane   (planes[p]),
            .coord_lo(lo_reg),
            .coord_hi(hi_reg),
            .reject  (reject[p])
        );
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, |reject};

endmodule

// ----- rtl/afc_checker.sv -----
// Port-level checker for the box frustum cull block, bound to the top level.
`include "aabb_frustum_cull_defines.svh"

module afc_checker
    import afc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int PEND_W = $clog2(PIPE_DEPTH + 2);

    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;

    always_comb
    begin
        pend_next = pend_reg + PEND_W'(s_tvalid && s_tready) - PEND_W'(m_tvalid && m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `AFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `AFC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[OUT_TDATA_W-1:1] == '0)
    `AFC_ASSERT_NOW(a_no_orphan, m_tvalid, pend_reg != '0)
    `AFC_ASSERT_NOW(a_depth, 1'b1, pend_reg <= PEND_W'(PIPE_DEPTH))
    `AFC_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready)

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (.*);
